[hw/rtl/hsv_pkg.sv]
// Shared types and constants of the HSV value adjust pipeline.
package hsv_pkg;

    localparam int CH_W         = 8;
    localparam int OFFSET_W     = 9;
    localparam int HUE_OUT_W    = 15;
    localparam int SAT_OUT_W    = 13;
    localparam int HUE_FRAC_DEF = 6;
    localparam int SAT_FRAC_DEF = 12;

    // ceil(n / 60) for n below 2^14 as (n + 59) * RECIP_60 >> RECIP_SHIFT
    localparam int CEIL_N_W     = 14;
    localparam int RECIP_60     = 17477;
    localparam int RECIP_W      = 15;
    localparam int RECIP_SHIFT  = 20;

    typedef enum logic [2:0] {
        SECT_RY,
        SECT_YG,
        SECT_GC,
        SECT_CB,
        SECT_BM,
        SECT_MR
    } sector_t;

    // Beat fields that ride along the divider stages.
    typedef struct packed {
        logic [CH_W-1:0] alpha;
        logic [CH_W-1:0] mx;
        logic            gray;
    } div_side_t;

endpackage

[hw/rtl/hsv_in_if.sv]
// Input pixel channel: valid/ready plus the RGBA fields.
interface hsv_in_if;
    logic                      valid;
    logic                      ready;
    logic [hsv_pkg::CH_W-1:0]  red_in;
    logic [hsv_pkg::CH_W-1:0]  green_in;
    logic [hsv_pkg::CH_W-1:0]  blue_in;
    logic [hsv_pkg::CH_W-1:0]  alpha_in;

    modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

[hw/rtl/hsv_out_if.sv]
// Output pixel channel: valid/ready plus adjusted RGBA and input HSV.
interface hsv_out_if;
    logic                          valid;
    logic                          ready;
    logic [hsv_pkg::CH_W-1:0]      red_out;
    logic [hsv_pkg::CH_W-1:0]      green_out;
    logic [hsv_pkg::CH_W-1:0]      blue_out;
    logic [hsv_pkg::CH_W-1:0]      alpha_out;
    logic [hsv_pkg::HUE_OUT_W-1:0] hue;
    logic [hsv_pkg::SAT_OUT_W-1:0] saturation;
    logic [hsv_pkg::CH_W-1:0]      value;

    modport source (output valid, red_out, green_out, blue_out, alpha_out, hue, saturation,
                    value, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, alpha_out, hue, saturation,
                    value, output ready);
endinterface

[hw/rtl/hsv_div_pipe.sv]
// Pipelined restoring dividers for hue and saturation, one quotient bit per stage.
module hsv_div_pipe #(
    parameter int QW = 15
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [hsv_pkg::CH_W+QW-1:0]   hue_num,
    input  logic [hsv_pkg::CH_W-1:0]      hue_den,
    input  logic [hsv_pkg::CH_W+QW-1:0]   sat_num,
    input  logic [hsv_pkg::CH_W-1:0]      sat_den,
    input  hsv_pkg::div_side_t            side_in,
    output logic                          out_valid,
    output logic [QW-1:0]                 hue_quo,
    output logic [QW-1:0]                 sat_quo,
    output hsv_pkg::div_side_t            side_out
);

    localparam int CW = hsv_pkg::CH_W;
    localparam int AW = CW + QW;

    // Upper CW bits hold the partial remainder, lower bits the numerator
    // bits still to come with quotient bits shifted in behind them.
    function automatic logic [AW-1:0] div_step(input logic [AW-1:0] acc,
                                               input logic [CW-1:0] den);
        logic [CW:0] trial;
        logic [CW:0] diff;
        trial = acc[AW-1:QW-1];
        diff  = trial - {1'b0, den};
        if (trial >= {1'b0, den})
            div_step = {diff[CW-1:0], acc[QW-2:0], 1'b1};
        else
            div_step = {trial[CW-1:0], acc[QW-2:0], 1'b0};
    endfunction

    logic [AW-1:0]       hacc_reg [QW];
    logic [AW-1:0]       sacc_reg [QW];
    logic [CW-1:0]       hden_reg [QW];
    logic [CW-1:0]       sden_reg [QW];
    hsv_pkg::div_side_t  side_reg [QW];
    logic [QW-1:0]       vld_reg;

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [AW-1:0]      hacc_src;
        logic [AW-1:0]      sacc_src;
        logic [CW-1:0]      hden_src;
        logic [CW-1:0]      sden_src;
        hsv_pkg::div_side_t side_src;
        logic               vld_src;

        if (k == 0)
        begin : g_first
            assign hacc_src = hue_num;
            assign sacc_src = sat_num;
            assign hden_src = hue_den;
            assign sden_src = sat_den;
            assign side_src = side_in;
            assign vld_src  = in_valid;
        end
        else
        begin : g_next
            assign hacc_src = hacc_reg[k-1];
            assign sacc_src = sacc_reg[k-1];
            assign hden_src = hden_reg[k-1];
            assign sden_src = sden_reg[k-1];
            assign side_src = side_reg[k-1];
            assign vld_src  = vld_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_src;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                hacc_reg[k] <= div_step(hacc_src, hden_src);
                sacc_reg[k] <= div_step(sacc_src, sden_src);
                hden_reg[k] <= hden_src;
                sden_reg[k] <= sden_src;
                side_reg[k] <= side_src;
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign hue_quo   = hacc_reg[QW-1][QW-1:0];
    assign sat_quo   = sacc_reg[QW-1][QW-1:0];
    assign side_out  = side_reg[QW-1];

endmodule

[hw/rtl/hsv_value_adjust.sv]
// Registered stages in order: stage A, the bit-per-stage hue and saturation dividers of
// QD = max(clog2(420 * 2^HUE_FRAC_BITS + 1), SAT_FRAC_BITS + 1) quotient bits, then B to F.
// Throughput: one pixel per cycle; a stall at the output holds every stage in place.
// Reset: asynchronous active low; clears all stage valid bits and sets the value
// offset to zero. Pipeline data registers are not reset.
module hsv_value_adjust #(
    parameter int HUE_FRAC_BITS = hsv_pkg::HUE_FRAC_DEF,
    parameter int SAT_FRAC_BITS = hsv_pkg::SAT_FRAC_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [hsv_pkg::OFFSET_W-1:0]  cfg_wr_data,
    hsv_in_if.sink                        pix_in,
    hsv_out_if.source                     pix_out
);

    localparam int CW   = hsv_pkg::CH_W;
    localparam int S    = 1 << HUE_FRAC_BITS;
    localparam int S60  = 60 * S;
    localparam int S360 = 360 * S;
    localparam int QH   = $clog2(420 * S + 1);
    localparam int QD   = (QH > SAT_FRAC_BITS + 1) ? QH : SAT_FRAC_BITS + 1;
    localparam int NW   = CW + QD;
    localparam int HW   = $clog2(S360);
    localparam int SW   = SAT_FRAC_BITS + 1;
    localparam int CPW  = SW + CW;
    localparam int GW   = $clog2(S60 + 1);
    localparam int XW   = CPW + GW;
    localparam int XSH  = SAT_FRAC_BITS + HUE_FRAC_BITS;
    localparam int YW   = hsv_pkg::CEIL_N_W;
    localparam int PW   = YW + hsv_pkg::RECIP_W;

    typedef struct packed {
        logic [CW-1:0] alpha;
        logic [CW-1:0] mx;
        logic [HW-1:0] hue;
        logic [SW-1:0] sat;
        logic [CW-1:0] v;
    } pass_t;

    logic en;
    logic f_vld_reg;

    assign en           = !f_vld_reg || pix_out.ready;
    assign pix_in.ready = en;

    // Value offset register
    logic signed [hsv_pkg::OFFSET_W-1:0] offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            offset_reg <= '0;
        else if (cfg_wr_en)
            offset_reg <= signed'(cfg_wr_data);
    end

    // Stage A: max, min, hue and saturation numerators
    logic [CW-1:0]    mx_a;
    logic [CW-1:0]    mn_a;
    logic [CW-1:0]    d_a;
    logic signed [11:0] m_a;
    logic signed [11:0] dd_a;
    logic signed [11:0] rr_a;
    logic signed [11:0] gg_a;
    logic signed [11:0] bb_a;

    always_comb
    begin
        mx_a = pix_in.red_in;
        if (pix_in.green_in > mx_a) mx_a = pix_in.green_in;
        if (pix_in.blue_in > mx_a)  mx_a = pix_in.blue_in;
        mn_a = pix_in.red_in;
        if (pix_in.green_in < mn_a) mn_a = pix_in.green_in;
        if (pix_in.blue_in < mn_a)  mn_a = pix_in.blue_in;
        d_a  = mx_a - mn_a;
        dd_a = signed'({4'd0, d_a});
        rr_a = signed'({4'd0, pix_in.red_in});
        gg_a = signed'({4'd0, pix_in.green_in});
        bb_a = signed'({4'd0, pix_in.blue_in});
        // Sector weight times d plus delta; never negative
        if (mx_a == pix_in.red_in)
            m_a = 12'sd6 * dd_a + (gg_a - bb_a);
        else if (mx_a == pix_in.green_in)
            m_a = 12'sd2 * dd_a + (bb_a - rr_a);
        else
            m_a = 12'sd4 * dd_a + (rr_a - gg_a);
    end

    logic                a_vld_reg;
    logic [NW-1:0]       a_hnum_reg;
    logic [NW-1:0]       a_snum_reg;
    logic [CW-1:0]       a_hden_reg;
    logic [CW-1:0]       a_sden_reg;
    hsv_pkg::div_side_t  a_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (en)
            a_vld_reg <= pix_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_hnum_reg       <= NW'(m_a[10:0]) * NW'(S60);
            a_snum_reg       <= NW'(d_a) << SAT_FRAC_BITS;
            a_hden_reg       <= d_a;
            a_sden_reg       <= mx_a;
            a_side_reg.alpha <= pix_in.alpha_in;
            a_side_reg.mx    <= mx_a;
            a_side_reg.gray  <= (d_a == '0);
        end
    end

    // Divider stages
    logic               dv_vld;
    logic [QD-1:0]      dv_hq;
    logic [QD-1:0]      dv_sq;
    hsv_pkg::div_side_t dv_side;

    hsv_div_pipe #(
        .QW (QD)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (a_vld_reg),
        .hue_num   (a_hnum_reg),
        .hue_den   (a_hden_reg),
        .sat_num   (a_snum_reg),
        .sat_den   (a_sden_reg),
        .side_in   (a_side_reg),
        .out_valid (dv_vld),
        .hue_quo   (dv_hq),
        .sat_quo   (dv_sq),
        .side_out  (dv_side)
    );

    // Stage B: hue wrap, gray override, clamped value
    logic [HW-1:0]      hue_b;
    logic [SW-1:0]      sat_b;
    logic [CW-1:0]      v_b;
    logic signed [9:0]  vs_b;

    always_comb
    begin
        if (dv_side.gray)
            hue_b = '0;
        else if (dv_hq >= QD'(S360))
            hue_b = HW'(dv_hq - QD'(S360));
        else
            hue_b = HW'(dv_hq);
        sat_b = dv_side.gray ? '0 : SW'(dv_sq);
        vs_b  = signed'({2'b00, dv_side.mx}) + 10'(offset_reg);
        if (vs_b < 10'sd0)
            v_b = '0;
        else if (vs_b > 10'sd255)
            v_b = '1;
        else
            v_b = vs_b[CW-1:0];
    end

    logic  b_vld_reg;
    pass_t b_pass_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else if (en)
            b_vld_reg <= dv_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_pass_reg.alpha <= dv_side.alpha;
            b_pass_reg.mx    <= dv_side.mx;
            b_pass_reg.hue   <= hue_b;
            b_pass_reg.sat   <= sat_b;
            b_pass_reg.v     <= v_b;
        end
    end

    // Stage C: sector, offset within sector, chroma
    hsv_pkg::sector_t sect_c;
    logic [HW-1:0]    f_c;

    always_comb
    begin
        if (b_pass_reg.hue >= HW'(5 * S60))
        begin
            sect_c = hsv_pkg::SECT_MR;
            f_c    = b_pass_reg.hue - HW'(5 * S60);
        end
        else if (b_pass_reg.hue >= HW'(4 * S60))
        begin
            sect_c = hsv_pkg::SECT_BM;
            f_c    = b_pass_reg.hue - HW'(4 * S60);
        end
        else if (b_pass_reg.hue >= HW'(3 * S60))
        begin
            sect_c = hsv_pkg::SECT_CB;
            f_c    = b_pass_reg.hue - HW'(3 * S60);
        end
        else if (b_pass_reg.hue >= HW'(2 * S60))
        begin
            sect_c = hsv_pkg::SECT_GC;
            f_c    = b_pass_reg.hue - HW'(2 * S60);
        end
        else if (b_pass_reg.hue >= HW'(S60))
        begin
            sect_c = hsv_pkg::SECT_YG;
            f_c    = b_pass_reg.hue - HW'(S60);
        end
        else
        begin
            sect_c = hsv_pkg::SECT_RY;
            f_c    = b_pass_reg.hue;
        end
    end

    logic             c_vld_reg;
    pass_t            c_pass_reg;
    hsv_pkg::sector_t c_sect_reg;
    logic [GW-1:0]    c_f_reg;
    logic [CPW-1:0]   c_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_vld_reg <= 1'b0;
        else if (en)
            c_vld_reg <= b_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_pass_reg <= b_pass_reg;
            c_sect_reg <= sect_c;
            c_f_reg    <= GW'(f_c);
            c_c_reg    <= CPW'(b_pass_reg.sat) * CPW'(b_pass_reg.v);
        end
    end

    // Stage D: weight of the middle channel's shortfall, and the low channel's drop
    logic [GW-1:0] gp_d;
    logic [CW-1:0] z_d;

    always_comb
    begin
        case (c_sect_reg)
            hsv_pkg::SECT_YG, hsv_pkg::SECT_CB, hsv_pkg::SECT_MR: gp_d = c_f_reg;
            default:                                               gp_d = GW'(S60) - c_f_reg;
        endcase
        z_d = CW'(c_c_reg >> SAT_FRAC_BITS) + CW'(|c_c_reg[SAT_FRAC_BITS-1:0]);
    end

    logic             d_vld_reg;
    pass_t            d_pass_reg;
    hsv_pkg::sector_t d_sect_reg;
    logic [XW-1:0]    d_x_reg;
    logic [CW-1:0]    d_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_vld_reg <= 1'b0;
        else if (en)
            d_vld_reg <= c_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_pass_reg <= c_pass_reg;
            d_sect_reg <= c_sect_reg;
            d_x_reg    <= XW'(c_c_reg) * XW'(gp_d);
            d_z_reg    <= z_d;
        end
    end

    // Stage E: ceil by the power-of-two part, then reciprocal multiply for the /60
    logic [YW-1:0] y_e;
    logic [YW-1:0] n_e;

    always_comb
    begin
        y_e = YW'(d_x_reg >> XSH) + YW'(|d_x_reg[XSH-1:0]);
        n_e = y_e + YW'(59);
    end

    logic             e_vld_reg;
    pass_t            e_pass_reg;
    hsv_pkg::sector_t e_sect_reg;
    logic [PW-1:0]    e_prod_reg;
    logic [CW-1:0]    e_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_vld_reg <= 1'b0;
        else if (en)
            e_vld_reg <= d_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_pass_reg <= d_pass_reg;
            e_sect_reg <= d_sect_reg;
            e_prod_reg <= PW'(n_e) * PW'(hsv_pkg::RECIP_60);
            e_z_reg    <= d_z_reg;
        end
    end

    // Stage F: rebuild channels into the output register
    logic [CW-1:0] mid_f;
    logic [CW-1:0] low_f;
    logic [CW-1:0] r_f;
    logic [CW-1:0] g_f;
    logic [CW-1:0] b_f;

    always_comb
    begin
        mid_f = e_pass_reg.v - CW'(e_prod_reg >> hsv_pkg::RECIP_SHIFT);
        low_f = e_pass_reg.v - e_z_reg;
        case (e_sect_reg)
            hsv_pkg::SECT_RY: begin r_f = e_pass_reg.v; g_f = mid_f;        b_f = low_f;        end
            hsv_pkg::SECT_YG: begin r_f = mid_f;        g_f = e_pass_reg.v; b_f = low_f;        end
            hsv_pkg::SECT_GC: begin r_f = low_f;        g_f = e_pass_reg.v; b_f = mid_f;        end
            hsv_pkg::SECT_CB: begin r_f = low_f;        g_f = mid_f;        b_f = e_pass_reg.v; end
            hsv_pkg::SECT_BM: begin r_f = mid_f;        g_f = low_f;        b_f = e_pass_reg.v; end
            default:          begin r_f = e_pass_reg.v; g_f = low_f;        b_f = mid_f;        end
        endcase
    end

    pass_t         f_pass_reg;
    logic [CW-1:0] f_r_reg;
    logic [CW-1:0] f_g_reg;
    logic [CW-1:0] f_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_vld_reg <= 1'b0;
        else if (en)
            f_vld_reg <= e_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_pass_reg <= e_pass_reg;
            f_r_reg    <= r_f;
            f_g_reg    <= g_f;
            f_b_reg    <= b_f;
        end
    end

    assign pix_out.valid      = f_vld_reg;
    assign pix_out.red_out    = f_r_reg;
    assign pix_out.green_out  = f_g_reg;
    assign pix_out.blue_out   = f_b_reg;
    assign pix_out.alpha_out  = f_pass_reg.alpha;
    assign pix_out.hue        = hsv_pkg::HUE_OUT_W'(f_pass_reg.hue);
    assign pix_out.saturation = hsv_pkg::SAT_OUT_W'(f_pass_reg.sat);
    assign pix_out.value      = f_pass_reg.mx;

    // The divider never yields a saturation above one
    a_sat_le_one: assert property (@(posedge clk) disable iff (!rst_n)
        b_vld_reg |-> b_pass_reg.sat <= SW'(1 << SAT_FRAC_BITS))
        else $error("saturation quotient above one");

    // The low channel's drop never exceeds the adjusted value
    a_low_le_v: assert property (@(posedge clk) disable iff (!rst_n)
        e_vld_reg |-> e_z_reg <= e_pass_reg.v)
        else $error("low channel drop exceeds value");

    // One channel always carries the full adjusted value
    a_peak_is_v: assert property (@(posedge clk) disable iff (!rst_n)
        f_vld_reg |-> (f_r_reg == f_pass_reg.v || f_g_reg == f_pass_reg.v
                       || f_b_reg == f_pass_reg.v))
        else $error("no channel equals adjusted value");

    // A stalled output beat holds in the output register
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        f_vld_reg && !pix_out.ready |=> f_vld_reg && $stable(f_r_reg) && $stable(f_pass_reg))
        else $error("stalled output beat changed");

endmodule

[dv/hsv_value_adjust_checker.sv]
// Checker for hsv_value_adjust: predicts each pixel from the input beats and compares outputs.
module hsv_value_adjust_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [hsv_pkg::OFFSET_W-1:0] cfg_wr_data,
    hsv_in_if                            pix_in,
    hsv_out_if                           pix_out,
    output int                           fail_count,
    output int                           pending
);

    localparam longint HUE_SCALE = 64;
    localparam longint SIXTY     = 60 * HUE_SCALE;
    localparam longint FULL_TURN = 360 * HUE_SCALE;
    localparam int     SAT_SHIFT = 12;

    typedef struct {
        logic [hsv_pkg::CH_W-1:0]      red;
        logic [hsv_pkg::CH_W-1:0]      green;
        logic [hsv_pkg::CH_W-1:0]      blue;
        logic [hsv_pkg::CH_W-1:0]      alpha;
        logic [hsv_pkg::HUE_OUT_W-1:0] hue;
        logic [hsv_pkg::SAT_OUT_W-1:0] sat;
        logic [hsv_pkg::CH_W-1:0]      value;
    } adjusted_pixel_t;

    adjusted_pixel_t expected_pixels[$];
    logic signed [hsv_pkg::OFFSET_W-1:0] offset;

    function automatic adjusted_pixel_t adjust_pixel(int r, int g, int b, int a,
                                                     int ofs);
        adjusted_pixel_t res;
        int mx, mn, d, v;
        longint t, hue, sat, den, c, big, sect, f, gw, mid, base, pr, pg, pb;
        hsv_pkg::sector_t sec;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        hue = 0;
        sat = 0;
        if (d != 0)
        begin
            if (mx == r)
                t = FULL_TURN * d + SIXTY * (g - b);
            else if (mx == g)
                t = 2 * SIXTY * d + SIXTY * (b - r);
            else
                t = 4 * SIXTY * d + SIXTY * (r - g);
            hue = t / d;
            if (hue >= FULL_TURN) hue -= FULL_TURN;
        end
        if (mx != 0) sat = (longint'(d) << SAT_SHIFT) / mx;
        v = mx + ofs;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        res.alpha = a[7:0];
        res.hue   = hue[hsv_pkg::HUE_OUT_W-1:0];
        res.sat   = sat[hsv_pkg::SAT_OUT_W-1:0];
        res.value = mx[7:0];
        if (sat == 0)
        begin
            res.red   = v[7:0];
            res.green = v[7:0];
            res.blue  = v[7:0];
        end
        else
        begin
            den  = (longint'(1) << SAT_SHIFT) * SIXTY;
            c    = sat * v;
            big  = c * SIXTY;
            sect = hue / SIXTY;
            f    = hue - sect * SIXTY;
            gw   = sect[0] ? SIXTY - f : f;
            mid  = c * gw;
            base = longint'(v) * den - big;
            sec  = hsv_pkg::sector_t'(sect[2:0]);
            case (sec)
                hsv_pkg::SECT_RY: begin pr = big; pg = mid; pb = 0;   end
                hsv_pkg::SECT_YG: begin pr = mid; pg = big; pb = 0;   end
                hsv_pkg::SECT_GC: begin pr = 0;   pg = big; pb = mid; end
                hsv_pkg::SECT_CB: begin pr = 0;   pg = mid; pb = big; end
                hsv_pkg::SECT_BM: begin pr = mid; pg = 0;   pb = big; end
                default:          begin pr = big; pg = 0;   pb = mid; end
            endcase
            pr = (pr + base) / den;
            pg = (pg + base) / den;
            pb = (pb + base) / den;
            res.red   = pr[7:0];
            res.green = pg[7:0];
            res.blue  = pb[7:0];
        end
        return res;
    endfunction

    task automatic compare_field(string name, longint exp_v, longint act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    initial fail_count = 0;
    initial pending = 0;

    always @(posedge clk or negedge rst_n)
    begin
        adjusted_pixel_t exp_p;
        if (!rst_n)
        begin
            offset <= '0;
        end
        else
        begin
            if (cfg_wr_en) offset <= cfg_wr_data;
            if (pix_in.valid && pix_in.ready)
                expected_pixels.push_back(adjust_pixel(pix_in.red_in, pix_in.green_in,
                    pix_in.blue_in, pix_in.alpha_in, int'(offset)));
            if (pix_out.valid && pix_out.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("output beat with no pixel outstanding");
                    fail_count++;
                end
                else
                begin
                    exp_p = expected_pixels.pop_front();
                    compare_field("red_out", exp_p.red, pix_out.red_out);
                    compare_field("green_out", exp_p.green, pix_out.green_out);
                    compare_field("blue_out", exp_p.blue, pix_out.blue_out);
                    compare_field("alpha_out", exp_p.alpha, pix_out.alpha_out);
                    compare_field("hue", exp_p.hue, pix_out.hue);
                    compare_field("saturation", exp_p.sat, pix_out.saturation);
                    compare_field("value", exp_p.value, pix_out.value);
                end
            end
        end
        pending = expected_pixels.size();
    end
endmodule

[dv/tb_hsv_value_adjust.sv]
// Top of the hsv_value_adjust testbench: clock, reset, pixel stimulus and verdict.
module tb_hsv_value_adjust;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_wr_en;
    logic [hsv_pkg::OFFSET_W-1:0] cfg_wr_data;
    logic                         quiet;
    int                           fail_count;
    int                           pending;
    int                           stall_left;

    hsv_in_if  pix_in ();
    hsv_out_if pix_out ();

    hsv_value_adjust dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .pix_in     (pix_in),
        .pix_out    (pix_out)
    );

    hsv_value_adjust_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .pix_in     (pix_in),
        .pix_out    (pix_out),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver side: stall in random bursts unless the run is in its quiet tail.
    always @(posedge clk)
    begin
        int next_left;
        next_left = stall_left;
        if (next_left > 0)
            next_left--;
        else if (!quiet && $urandom_range(0, 7) == 0)
            next_left = $urandom_range(1, 11);
        stall_left <= next_left;
        pix_out.ready <= (next_left == 0);
    end

    task automatic send_pixel(int r, int g, int b, int a);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            pix_in.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        pix_in.valid    <= 1'b1;
        pix_in.red_in   <= r[7:0];
        pix_in.green_in <= g[7:0];
        pix_in.blue_in  <= b[7:0];
        pix_in.alpha_in <= a[7:0];
        @(posedge clk);
        while (!pix_in.ready) @(posedge clk);
    endtask

    // Drain the pipeline, then hold until the last stage is surely empty.
    task automatic drain_pipe();
        pix_in.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_offset(logic [hsv_pkg::OFFSET_W-1:0] ofs);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ofs;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_random_pixel();
        int r, g, b, kind;
        kind = $urandom_range(0, 9);
        r = $urandom_range(0, 255);
        g = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
        case (kind)
            0: begin g = r; b = r; end
            1: begin g = r; end
            2: begin b = g; end
            3: begin b = r; end
            4:
            begin
                r = $urandom_range(0, 1) * 255;
                g = $urandom_range(0, 1) * 255;
                b = $urandom_range(0, 1) * 255;
            end
            default: ;
        endcase
        send_pixel(r, g, b, $urandom_range(0, 255));
    endtask

    task automatic run_phase(int count);
        repeat (count) send_random_pixel();
        drain_pipe();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        quiet          = 1'b0;
        stall_left     = 0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        pix_in.valid   = 1'b0;
        pix_in.red_in  = '0;
        pix_in.green_in = '0;
        pix_in.blue_in = '0;
        pix_in.alpha_in = '0;
        pix_out.ready  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pixels at the reset offset: black, white, primaries, ties, hue wrap.
        send_pixel(0, 0, 0, 0);
        send_pixel(255, 255, 255, 255);
        send_pixel(255, 0, 0, 170);
        send_pixel(0, 255, 0, 85);
        send_pixel(0, 0, 255, 1);
        send_pixel(255, 255, 0, 128);
        send_pixel(0, 255, 255, 254);
        send_pixel(255, 0, 255, 127);
        send_pixel(128, 128, 128, 3);
        send_pixel(255, 0, 1, 9);
        send_pixel(200, 200, 100, 77);
        send_pixel(100, 200, 200, 66);
        send_pixel(200, 100, 200, 55);
        send_pixel(1, 0, 0, 44);
        send_pixel(255, 254, 254, 33);
        send_pixel(10, 20, 30, 22);
        send_pixel(0, 1, 255, 11);
        send_pixel(1, 1, 1, 240);
        drain_pipe();

        write_offset(9'h0FF);
        run_phase(300);
        write_offset(9'h101);
        run_phase(300);
        write_offset(9'h100);
        run_phase(250);
        write_offset(9'($urandom_range(0, 511)));
        run_phase(300);
        write_offset(9'h040);
        run_phase(300);
        write_offset(9'h000);
        quiet = 1'b1;
        run_phase(400);

        if (fail_count == 0)
            $display("tb_hsv_value_adjust OK");
        else
            $display("tb_hsv_value_adjust NOT OK");
        $finish;
    end

    initial
    begin
        #40000000;
        $display("tb_hsv_value_adjust NOT OK");
        $finish;
    end
endmodule
